### src/ttss_pkg.sv
// Shared types, constants and profile tables for the take-off setpoint sequencer.
`default_nettype none

package ttss_pkg;

  localparam int unsigned CoordW = 16;  // Q8.8 position width
  localparam int unsigned SW     = 17;  // profile value, Q1.16 unsigned
  localparam int unsigned ProdW  = 35;  // s times (end - start), signed

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_START_Z = 3'd2,
    CFG_END_X   = 3'd3,
    CFG_END_Y   = 3'd4,
    CFG_END_Z   = 3'd5
  } cfg_idx_e;

  // Input operation codes
  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  localparam logic [3:0]    SETUP_ARM   = 4'd10;  // count that raises the arm request
  localparam logic [3:0]    SETUP_DONE  = 4'd11;  // count at which profile time runs
  localparam logic [6:0]    T_END       = 7'd100; // end of profile in tenths
  localparam logic [6:0]    T_BLEND     = 7'd20;  // end of acceleration blend
  localparam logic [6:0]    T_DECEL     = 7'd80;  // start of deceleration blend
  localparam logic [6:0]    T_OFFSET    = 7'd10;  // linear segment time offset
  localparam logic [16:0]   S_ONE       = 17'h10000;
  localparam logic [15:0]   END_Z_RESET = 16'hFE00; // minus two metres

  // Stage load enables handed to the axis datapath
  typedef struct packed {
    logic prod_en;
    logic out_en;
  } ttss_adv_t;

  // floor(r*r*512/25) for r = 0..20
  function automatic logic [13:0] quad_floor(input logic [4:0] r);
    logic [13:0] v;
    case (r)
      5'd0:    v = 14'd0;
      5'd1:    v = 14'd20;
      5'd2:    v = 14'd81;
      5'd3:    v = 14'd184;
      5'd4:    v = 14'd327;
      5'd5:    v = 14'd512;
      5'd6:    v = 14'd737;
      5'd7:    v = 14'd1003;
      5'd8:    v = 14'd1310;
      5'd9:    v = 14'd1658;
      5'd10:   v = 14'd2048;
      5'd11:   v = 14'd2478;
      5'd12:   v = 14'd2949;
      5'd13:   v = 14'd3461;
      5'd14:   v = 14'd4014;
      5'd15:   v = 14'd4608;
      5'd16:   v = 14'd5242;
      5'd17:   v = 14'd5918;
      5'd18:   v = 14'd6635;
      5'd19:   v = 14'd7393;
      5'd20:   v = 14'd8192;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  // ceil(r*r*512/25): exact only where r is a multiple of five
  function automatic logic [13:0] quad_ceil(input logic [4:0] r);
    logic exact;
    exact = r inside {5'd0, 5'd5, 5'd10, 5'd15, 5'd20};
    return quad_floor(r) + {13'd0, ~exact};
  endfunction

endpackage

`default_nettype wire

### src/ttss_profile.sv
// Trapezoidal path parameter s(n), Q1.16, from profile time in tenths.
`default_nettype none

module ttss_profile
  import ttss_pkg::*;
(
  input  logic [6:0]    n_i,
  output logic [SW-1:0] s_o
);

  logic [6:0]  k;
  logic [16:0] kmul;
  logic [14:0] krec;
  logic [16:0] lin;
  logic [6:0]  rw;

  always_comb begin
    // linear segment: floor(k*4096/5) = k*819 + floor(k/5), k = n - 10
    k    = n_i - T_OFFSET;
    kmul = {10'd0, k} * 17'd819;
    krec = {8'd0, k} * 15'd205;  // floor(k/5) = (k*205) >> 10 for k <= 70
    lin  = kmul + {12'd0, krec[14:10]};
    rw   = T_END - n_i;
    if (n_i <= T_BLEND) begin
      s_o = {3'd0, quad_floor(n_i[4:0])};
    end else if (n_i <= T_DECEL) begin
      s_o = lin;
    end else begin
      s_o = S_ONE - {3'd0, quad_ceil(rw[4:0])};
    end
  end

endmodule

`default_nettype wire

### src/ttss_axis.sv
// One axis: start + floor(s*(end-start)/65536), saturated to Q8.8.
`default_nettype none

module ttss_axis
  import ttss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttss_adv_t         adv_i,
  input  logic [SW-1:0]     s_i,
  input  logic [CoordW-1:0] start_i,
  input  logic [CoordW-1:0] end_i,
  output logic [CoordW-1:0] sp_o
);

  logic signed [CoordW:0]   delta;
  logic signed [ProdW-1:0]  prod_d, prod_q;
  logic signed [18:0]       quot;
  logic signed [19:0]       sum;
  logic [CoordW-1:0]        sp_d, sp_q;

  always_comb begin
    delta  = $signed({end_i[CoordW-1], end_i}) - $signed({start_i[CoordW-1], start_i});
    prod_d = $signed({1'b0, s_i}) * delta;
  end

  // arithmetic shift gives the floor for negative products too
  always_comb begin
    quot = prod_q[ProdW-1:16];
    sum  = {quot[18], quot} + {{4{start_i[CoordW-1]}}, start_i};
    if (sum > 20'sd32767) begin
      sp_d = 16'h7FFF;
    end else if (sum < -20'sd32768) begin
      sp_d = 16'h8000;
    end else begin
      sp_d = sum[CoordW-1:0];
    end
  end

  // product stage and output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      sp_q   <= '0;
    end else begin
      if (adv_i.prod_en) begin
        prod_q <= prod_d;
      end
      if (adv_i.out_en) begin
        sp_q <= sp_d;
      end
    end
  end

  assign sp_o = sp_q;

endmodule

`default_nettype wire

### src/trapezoidal_takeoff_setpoint_sequencer.sv
// Top level of the take-off setpoint sequencer with trapezoidal profile.
//
// Input stream (s_axis_*): tuser carries the op (start request or 100 ms
// tick), tdata the start flag and the peer-running flag. A start transfer
// with start_value set arms the block once; later starts are dropped.
// Every tick while armed yields one result transfer on m_axis_*: a 3-axis
// Q8.8 setpoint, the arm request, the success status, and tlast = stopped.
// Ticks before arming or after the final stop produce nothing.
//
// Sequencer state is updated in the cycle the input transfer is taken, so
// an input is accepted every cycle while s_axis_tready is high. The
// setpoint goes through three registers: profile lookup, one 17x17
// multiply per axis, then floor, add and saturate. Throughput is one item
// per cycle; when the receiver stalls the three stages fill up and
// s_axis_tready drops only once all of them hold data.
//
// Reset (rst_ni, async, active low) clears the sequencer and empties the
// pipeline; the position registers return to 0 except end_z = -2 m.
// Config writes (cfg_we_i) are registered and must happen while idle.
`default_nettype none

module trapezoidal_takeoff_setpoint_sequencer
  import ttss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] start_value, [1] peer_running
  input  logic        s_axis_tuser,   // [0] op
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [15:0] x, [31:16] y, [47:32] z,
                                      // [48] arm_request, [49] status
  output logic        m_axis_tlast    // stopped
);

  // configuration registers
  logic [CoordW-1:0] start_x_q, start_y_q, start_z_q;
  logic [CoordW-1:0] end_x_q, end_y_q, end_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      start_z_q <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
      end_z_q   <= END_Z_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_X: start_x_q <= cfg_wdata_i;
        CFG_START_Y: start_y_q <= cfg_wdata_i;
        CFG_START_Z: start_z_q <= cfg_wdata_i;
        CFG_END_X:   end_x_q   <= cfg_wdata_i;
        CFG_END_Y:   end_y_q   <= cfg_wdata_i;
        CFG_END_Z:   end_z_q   <= cfg_wdata_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // sequencer state
  logic       started_q, started_d;
  logic       ticking_q, ticking_d;
  logic [3:0] setup_q, setup_d;
  logic [6:0] elapsed_q, elapsed_d;

  // pipeline handshake
  logic s1_v_q, s2_v_q, out_v_q;
  logic s1_rdy, s2_rdy, out_rdy;
  logic in_xfer;

  assign out_rdy       = !out_v_q || m_axis_tready;
  assign s2_rdy        = !s2_v_q || out_rdy;
  assign s1_rdy        = !s1_v_q || s2_rdy;
  assign s_axis_tready = s1_rdy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // per-tick decisions
  logic       emit, arm, status, stop;
  logic       run_time;
  logic [6:0] el_inc;

  always_comb begin
    started_d = started_q;
    ticking_d = ticking_q;
    setup_d   = setup_q;
    elapsed_d = elapsed_q;
    emit      = 1'b0;
    arm       = 1'b0;
    status    = 1'b0;
    stop      = 1'b0;
    run_time  = (setup_q == SETUP_DONE);
    el_inc    = (run_time && elapsed_q < T_END) ? elapsed_q + 7'd1 : elapsed_q;
    if (in_xfer) begin
      case (op_e'(s_axis_tuser))
        OP_START: begin
          if (s_axis_tdata[0] && !started_q) begin
            started_d = 1'b1;
            ticking_d = 1'b1;
            setup_d   = '0;
            elapsed_d = '0;
          end
        end
        OP_TICK: begin
          if (ticking_q) begin
            emit      = 1'b1;
            arm       = (setup_q == SETUP_ARM);
            elapsed_d = el_inc;
            if (run_time && el_inc == T_END) begin
              status = 1'b1;
              if (s_axis_tdata[1]) begin
                ticking_d = 1'b0;
                stop      = 1'b1;
              end
            end else if (setup_q < SETUP_DONE) begin
              setup_d = setup_q + 4'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      ticking_q <= 1'b0;
      setup_q   <= '0;
      elapsed_q <= '0;
    end else begin
      started_q <= started_d;
      ticking_q <= ticking_d;
      setup_q   <= setup_d;
      elapsed_q <= elapsed_d;
    end
  end

  // stage 1: profile value from time before this tick's advance
  logic [SW-1:0] s_d, s1_s_q;
  logic [2:0]    s1_flags_q, s2_flags_q, out_flags_q;  // {stop, status, arm}

  ttss_profile u_profile (
    .n_i (elapsed_q),
    .s_o (s_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= in_xfer && emit;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (out_rdy) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_s_q     <= s_d;
      s1_flags_q <= {stop, status, arm};
    end
    if (s2_rdy) begin
      s2_flags_q <= s1_flags_q;
    end
    if (out_rdy) begin
      out_flags_q <= s2_flags_q;
    end
  end

  // stages 2 and 3 per axis
  ttss_adv_t         adv;
  logic [CoordW-1:0] sp_x, sp_y, sp_z;

  assign adv.prod_en = s2_rdy;
  assign adv.out_en  = out_rdy;

  ttss_axis u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .s_i     (s1_s_q),
    .start_i (start_x_q),
    .end_i   (end_x_q),
    .sp_o    (sp_x)
  );

  ttss_axis u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .s_i     (s1_s_q),
    .start_i (start_y_q),
    .end_i   (end_y_q),
    .sp_o    (sp_y)
  );

  ttss_axis u_axis_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .s_i     (s1_s_q),
    .start_i (start_z_q),
    .end_i   (end_z_q),
    .sp_o    (sp_z)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'd0, out_flags_q[1], out_flags_q[0], sp_z, sp_y, sp_x};
  assign m_axis_tlast  = out_flags_q[2];

  // checks
  a_stop_implies_success : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[49])
    else $error("stop transfer without success status");

  a_arm_not_with_success : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[48] && m_axis_tdata[49]))
    else $error("arm request and success in one transfer");

  a_ticking_needs_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ticking_q |-> started_q)
    else $error("ticking while never started");

  a_counters_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    setup_q <= SETUP_DONE && elapsed_q <= T_END)
    else $error("sequencer counter out of range");

  a_time_runs_after_setup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    elapsed_q != 7'd0 |-> setup_q == SETUP_DONE)
    else $error("profile time advanced during setup");

endmodule

`default_nettype wire
